/* sv/fpr_pkg.sv */
// Shared constants and types for the FIFO page replacement block.
package fpr_pkg;

  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned CFG_W   = 3;
  localparam logic [CFG_W-1:0] CFG_RESET = 3'd4;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 32'hFFFF_FFFF;

  // Completion status handed from the controller to the result stage.
  typedef struct packed {
    logic done;
    logic hit;
    logic ev_valid;
  } fpr_status_t;

endpackage

/* sv/fpr_frame_mem.sv */
// Frame store: one write port and one registered read port.
module fpr_frame_mem
  #(
    parameter int unsigned DEPTH = 4,
    parameter int unsigned WIDTH = 8,
    parameter int unsigned AW    = 2
  )
  (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
  );

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/fpr_ctrl.sv */
// Scan and update sequencer: compares a page with each resident frame, then writes back on a miss.
module fpr_ctrl
  import fpr_pkg::*;
  #(
    parameter int unsigned FRAMES    = 4,
    parameter int unsigned PAGE_BITS = 8,
    parameter int unsigned IDX_W     = 2,
    parameter int unsigned CNT_W     = 3
  )
  (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PAGE_BITS-1:0] in_page,
    input  logic [CNT_W-1:0]     limit,
    input  logic                 out_free,
    output logic                 mem_rd_en,
    output logic [IDX_W-1:0]     mem_rd_addr,
    input  logic [PAGE_BITS-1:0] mem_rd_data,
    output logic                 mem_wr_en,
    output logic [IDX_W-1:0]     mem_wr_addr,
    output logic [PAGE_BITS-1:0] mem_wr_data,
    output fpr_status_t          status,
    output logic [PAGE_BITS-1:0] ev_page
  );

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_DONE = 4'b0100,
    S_SPARE = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      occ_r, occ_nxt;
  logic [IDX_W-1:0]      oldest_r, oldest_nxt;
  logic [CNT_W-1:0]      iss_cnt_r, iss_cnt_nxt;
  logic [IDX_W-1:0]      iss_ptr_r, iss_ptr_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic                  first_r, first_nxt;
  logic                  hit_r, hit_nxt;
  logic [PAGE_BITS-1:0]  page_r, page_nxt;
  logic [PAGE_BITS-1:0]  old_page_r, old_page_nxt;
  logic                  evict;
  logic [CNT_W:0]        wr_sum;

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] p);
    ring_inc = (p == IDX_W'(FRAMES - 1)) ? '0 : p + 1'b1;
  endfunction

  // Slot of the new page: the oldest pointer plus the occupancy, modulo the frame count.
  // On an eviction with every frame occupied this is the slot the oldest page gives up.
  assign wr_sum = (CNT_W+1)'(oldest_r) + {1'b0, occ_r};
  assign evict  = (occ_r >= limit);

  assign in_stall    = (state_r != S_IDLE);
  assign mem_wr_addr = (wr_sum >= (CNT_W+1)'(FRAMES)) ?
                       IDX_W'(wr_sum - (CNT_W+1)'(FRAMES)) : IDX_W'(wr_sum);
  assign mem_wr_data = page_r;
  assign ev_page     = old_page_r;

  always_comb begin
    state_nxt    = state_r;
    occ_nxt      = occ_r;
    oldest_nxt   = oldest_r;
    iss_cnt_nxt  = iss_cnt_r;
    iss_ptr_nxt  = iss_ptr_r;
    rd_vld_nxt   = 1'b0;
    first_nxt    = 1'b0;
    hit_nxt      = hit_r;
    page_nxt     = page_r;
    old_page_nxt = old_page_r;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = iss_ptr_r;
    mem_wr_en    = 1'b0;
    status       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          page_nxt = in_page;
          hit_nxt  = 1'b0;
          if (occ_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = oldest_r;
            iss_cnt_nxt = CNT_W'(1);
            iss_ptr_nxt = ring_inc(oldest_r);
            rd_vld_nxt  = 1'b1;
            first_nxt   = 1'b1;
            state_nxt   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_vld_r && (mem_rd_data == page_r)) begin
          hit_nxt = 1'b1;
        end
        if (first_r) begin
          old_page_nxt = mem_rd_data;
        end
        if (iss_cnt_r < occ_r) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = iss_ptr_r;
          iss_cnt_nxt = iss_cnt_r + 1'b1;
          iss_ptr_nxt = ring_inc(iss_ptr_r);
          rd_vld_nxt  = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          status.done     = 1'b1;
          status.hit      = hit_r;
          status.ev_valid = !hit_r && evict;
          if (!hit_r) begin
            mem_wr_en = 1'b1;
            if (evict) begin
              oldest_nxt = ring_inc(oldest_r);
            end else begin
              occ_nxt = occ_r + 1'b1;
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      occ_r    <= '0;
      oldest_r <= '0;
      rd_vld_r <= 1'b0;
      first_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      occ_r    <= occ_nxt;
      oldest_r <= oldest_nxt;
      rd_vld_r <= rd_vld_nxt;
      first_r  <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_cnt_r  <= iss_cnt_nxt;
    iss_ptr_r  <= iss_ptr_nxt;
    hit_r      <= hit_nxt;
    page_r     <= page_nxt;
    old_page_r <= old_page_nxt;
  end

endmodule

/* sv/fifo_page_replacement.sv */
// Top level of the FIFO page replacement block: configuration, totals and result register.
//
// Each input transaction carries one page reference. The block checks it against the
// resident pages, which sit in a small synchronous frame memory kept as a ring in arrival
// order, and returns one result transaction: whether the page hit, whether a miss evicted
// the oldest page and which page that was (zero otherwise), and the saturating running hit
// and miss totals including this reference. A transaction is accepted in the cycle that
// issues its first frame read, or that moves straight to the write-back when the store is
// empty. The controller reads one resident frame per cycle through the single memory read
// port, compares the last frame read, and then does the write-back and result update, which
// waits while the output register is full and stalled; the result is loaded into the output
// register with that update. The next transaction can be accepted in the cycle after that.
// One item is in work at a time; a finished result waits in the output register while the
// next item is accepted and scanned. The frames_in_use register limits how many frames are
// filled: zero acts as one, values above FRAMES act as FRAMES, and if it is lowered below
// the current occupancy the resident pages stay and each later miss swaps out exactly one
// oldest page. Write it only while the block is idle.
module fifo_page_replacement
  import fpr_pkg::*;
  #(
    parameter int unsigned FRAMES    = 4,
    parameter int unsigned PAGE_BITS = 8
  )
  (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PAGE_BITS-1:0] in_page,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 out_hit,
    output logic                 out_evicted_valid,
    output logic [PAGE_BITS-1:0] out_evicted_page,
    output logic [TOTAL_W-1:0]   out_hit_count,
    output logic [TOTAL_W-1:0]   out_miss_count,
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_wdata
  );

  localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CNT_W = $clog2(FRAMES + 1);
  localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0]     frames_in_use_r;
  logic [CMP_W-1:0]     lim_raw;
  logic [CNT_W-1:0]     limit;
  logic                 out_free;
  fpr_status_t          status;
  logic [PAGE_BITS-1:0] ev_page;

  logic                 mem_rd_en;
  logic [IDX_W-1:0]     mem_rd_addr;
  logic [PAGE_BITS-1:0] mem_rd_data;
  logic                 mem_wr_en;
  logic [IDX_W-1:0]     mem_wr_addr;
  logic [PAGE_BITS-1:0] mem_wr_data;

  logic                 out_valid_r, out_valid_nxt;
  logic                 hit_o_r;
  logic                 ev_valid_o_r;
  logic [PAGE_BITS-1:0] ev_page_o_r;
  logic [TOTAL_W-1:0]   hit_total_r, hit_total_nxt;
  logic [TOTAL_W-1:0]   miss_total_r, miss_total_nxt;

  // Clamp the configured limit into the range one to FRAMES.
  always_comb begin
    lim_raw = (frames_in_use_r == '0) ? CMP_W'(1) : CMP_W'(frames_in_use_r);
    if (lim_raw > CMP_W'(FRAMES)) begin
      lim_raw = CMP_W'(FRAMES);
    end
  end
  assign limit = CNT_W'(lim_raw);

  // The result register can take a new transaction when empty or being drained this cycle.
  assign out_free = !out_valid_r || !out_stall;

  fpr_frame_mem #(
    .DEPTH (FRAMES),
    .WIDTH (PAGE_BITS),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  fpr_ctrl #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_page     (in_page),
    .limit       (limit),
    .out_free    (out_free),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .status      (status),
    .ev_page     (ev_page)
  );

  // Totals saturate at their all-ones value.
  always_comb begin
    hit_total_nxt  = hit_total_r;
    miss_total_nxt = miss_total_r;
    out_valid_nxt  = out_valid_r;
    if (status.done) begin
      out_valid_nxt = 1'b1;
      if (status.hit) begin
        if (hit_total_r != TOTAL_MAX) begin
          hit_total_nxt = hit_total_r + 1'b1;
        end
      end else begin
        if (miss_total_r != TOTAL_MAX) begin
          miss_total_nxt = miss_total_r + 1'b1;
        end
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= CFG_RESET;
      out_valid_r     <= 1'b0;
      hit_total_r     <= '0;
      miss_total_r    <= '0;
    end else begin
      if (cfg_we) begin
        frames_in_use_r <= cfg_wdata;
      end
      out_valid_r  <= out_valid_nxt;
      hit_total_r  <= hit_total_nxt;
      miss_total_r <= miss_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done) begin
      hit_o_r      <= status.hit;
      ev_valid_o_r <= status.ev_valid;
      ev_page_o_r  <= status.ev_valid ? ev_page : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = hit_o_r;
  assign out_evicted_valid = ev_valid_o_r;
  assign out_evicted_page  = ev_page_o_r;
  assign out_hit_count     = hit_total_r;
  assign out_miss_count    = miss_total_r;

endmodule
